// ===== hdl/fqt_pkg.sv =====
// ----------------------------------------------------------------------------
// fqt_pkg
// Types, constants and codes shared by the failure quarantine table.
// ----------------------------------------------------------------------------
package fqt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
	localparam logic [19:0] STRENGTH_HALF = 20'd500000;
	localparam logic [19:0] STRENGTH_STEP = 20'd100000;
	localparam logic [19:0] STRENGTH_FULL = 20'd1000000;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// One table row: key, count, strength, stored error code.
	localparam int ROW_W = 64 + 16 + 20 + 8;

	localparam logic [1:0] ACT_REPORT = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [0:0] REG_THRESHOLD = 1'd0;
	localparam logic [0:0] REG_DECAY = 1'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH,
		S_SREAD,
		S_SCMP,
		S_UPDATE,
		S_TREAD,
		S_TWRITE,
		S_CREAD,
		S_CWRITE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [63:0] key;
		logic [15:0] count;
		logic [19:0] strength;
		logic [7:0] fail_code;
	} row_t;

endpackage

// ===== hdl/fqt_ram.sv =====
// ----------------------------------------------------------------------------
// fqt_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fqt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== hdl/fqt_hash.sv =====
// ----------------------------------------------------------------------------
// fqt_hash
// FNV-1a over the eight identifier bytes, one byte per cycle.
// ----------------------------------------------------------------------------
module fqt_hash
	import fqt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [63:0] id,
	output logic busy,
	output logic [63:0] hash
);

	logic [63:0] id_q;
	logic [63:0] h_q;
	logic [2:0] cnt_q;
	logic busy_q;
	logic [63:0] mixed;

	// The prime has bits 40, 8, 7, 5, 4, 1, 0 set, so the product is a shift sum.
	assign mixed = h_q ^ {56'd0, id_q[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			id_q <= id;
			h_q <= FNV_BASIS;
		end else if (busy_q) begin
			id_q <= {8'd0, id_q[63:8]};
			h_q <= mixed + (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
				+ (mixed << 4) + (mixed << 1);
		end
	end

	assign busy = busy_q;
	assign hash = h_q;

endmodule

// ===== hdl/failure_quarantine_table_core.sv =====
// ----------------------------------------------------------------------------
// failure_quarantine_table_core
// Table of failure patterns with quarantine strengths.
// ----------------------------------------------------------------------------
// One request is taken at a time. A report or a query hashes the identifier and
// then scans the table, reading and comparing each occupied entry until the key
// matches; a clear scans the same way without hashing. A report then writes the
// row if it hits or the table has room; a clear that hits moves each later entry
// down with a read and a write; then the result is given. A tick reads and writes
// every occupied entry. Each step waits on the single port of the table memory.
module failure_quarantine_table_core
	import fqt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// action[1:0], pattern_id[65:2], error_code[73:66], elapsed_ms[89:74], pad
	input  logic [95:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// status[1:0], found[2], strength_out[22:3], blocked[23], count_out[39:24],
	// entries_in_use[46:40], failures_total[78:47], pad
	output logic [79:0] m_tdata,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [19:0] cfg_wdata
);

	state_t state_q, state_d;
	logic [7:0] thr_q;
	logic [19:0] decay_q;
	logic [1:0] act_q;
	logic [63:0] pid_q;
	logic [7:0] err_q;
	logic [35:0] dec_q;
	logic [USED_W-1:0] used_q;
	logic [31:0] total_q;
	logic [IDX_W:0] idx_q;
	logic hit_q;
	row_t row_q;
	logic hash_start, hash_busy;
	logic [63:0] hash;
	logic [63:0] key;
	logic ram_we;
	logic [IDX_W-1:0] ram_addr;
	row_t ram_wdata, ram_rdata;
	logic [1:0] st_q;
	logic fnd_q, blk_q;
	logic [19:0] str_q;
	logic [15:0] cnt_q;
	logic oval_q;
	logic [15:0] new_cnt;
	logic [16:0] over;
	logic [36:0] s_wide;
	logic [19:0] new_str;

	fqt_hash u_hash (
		.clk(clk), .arst_n(arst_n), .start(hash_start), .id(s_tdata[65:2]),
		.busy(hash_busy), .hash(hash)
	);

	fqt_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign key = (act_q == ACT_CLEAR) ? pid_q : hash;
	assign s_tready = (state_q == S_IDLE) && !oval_q;
	assign hash_start = s_tvalid && s_tready;

	// Report arithmetic on the row being updated.
	assign new_cnt = (row_q.count == COUNT_MAX) ? row_q.count : row_q.count + 16'd1;
	assign over = {1'b0, new_cnt} - {9'd0, thr_q};
	assign s_wide = {17'd0, STRENGTH_HALF} + {3'd0, STRENGTH_STEP} * {17'd0, over[15:0]};
	assign new_str = (s_wide > {17'd0, STRENGTH_FULL}) ? STRENGTH_FULL : s_wide[19:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (hash_start) begin
					case (s_tdata[1:0])
						ACT_TICK: state_d = S_TREAD;
						ACT_CLEAR: state_d = S_SREAD;
						default: state_d = S_HASH;
					endcase
				end
			end
			S_HASH: if (!hash_busy) state_d = S_SREAD;
			S_SREAD: state_d = ({1'b0, idx_q} < {1'b0, used_q}) ? S_SCMP : S_UPDATE;
			S_SCMP: state_d = (ram_rdata.key == key) ? S_UPDATE : S_SREAD;
			S_UPDATE: begin
				if (act_q == ACT_CLEAR && hit_q) state_d = S_CREAD;
				else state_d = S_DONE;
			end
			S_TREAD: state_d = ({1'b0, idx_q} < {1'b0, used_q}) ? S_TWRITE : S_DONE;
			S_TWRITE: state_d = S_TREAD;
			// The occupancy has already dropped by one, so the last row to move
			// sits at the new occupancy.
			S_CREAD: state_d = ({1'b0, idx_q} < {1'b0, used_q}) ? S_CWRITE : S_DONE;
			S_CWRITE: state_d = S_CREAD;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = idx_q[IDX_W-1:0];
		ram_wdata = row_q;
		case (state_q)
			S_UPDATE: begin
				ram_we = (act_q == ACT_REPORT) && (hit_q || used_q < USED_W'(TABLE_ENTRIES));
				ram_wdata.count = new_cnt;
				ram_wdata.fail_code = err_q;
				ram_wdata.strength = (new_cnt >= {8'd0, thr_q}) ? new_str : row_q.strength;
				if (!hit_q) begin
					ram_wdata.key = hash;
					ram_wdata.count = 16'd1;
					ram_wdata.strength = (16'd1 >= {8'd0, thr_q}) ? new_str : 20'd0;
				end
			end
			S_TWRITE: begin
				ram_we = 1'b1;
				ram_addr = idx_q[IDX_W-1:0];
				ram_wdata = ram_rdata;
				ram_wdata.strength = ({16'd0, ram_rdata.strength} > dec_q)
					? ram_rdata.strength - dec_q[19:0] : 20'd0;
			end
			S_CREAD: ram_addr = IDX_W'(idx_q + 1);
			S_CWRITE: begin
				ram_we = 1'b1;
				ram_wdata = ram_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			thr_q <= 8'd3;
			decay_q <= 20'd10;
			used_q <= '0;
			total_q <= '0;
			oval_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == REG_THRESHOLD) thr_q <= cfg_wdata[7:0];
			if (cfg_we && cfg_index == REG_DECAY) decay_q <= cfg_wdata;
			if (m_tvalid && m_tready) oval_q <= 1'b0;
			if (state_q == S_DONE) oval_q <= 1'b1;
			if (state_q == S_UPDATE && act_q == ACT_REPORT) begin
				total_q <= total_q + 32'd1;
				if (!hit_q && used_q < USED_W'(TABLE_ENTRIES)) used_q <= used_q + 1'b1;
			end
			if (state_q == S_UPDATE && act_q == ACT_CLEAR && hit_q) used_q <= used_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q <= s_tdata[1:0];
				pid_q <= s_tdata[65:2];
				err_q <= s_tdata[73:66];
				idx_q <= '0;
				hit_q <= 1'b0;
				row_q <= '0;
			end
			S_SCMP: begin
				if (ram_rdata.key == key) begin
					hit_q <= 1'b1;
					row_q <= ram_rdata;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_TWRITE: idx_q <= idx_q + 1'b1;
			S_CWRITE: idx_q <= idx_q + 1'b1;
			default: ;
		endcase
		if (state_q == S_IDLE) dec_q <= {20'd0, s_tdata[89:74]} * {16'd0, decay_q};
		if (state_q == S_UPDATE) begin
			st_q <= ST_OK;
			fnd_q <= hit_q;
			str_q <= hit_q ? row_q.strength : 20'd0;
			cnt_q <= hit_q ? row_q.count : 16'd0;
			blk_q <= 1'b0;
			case (act_q)
				ACT_REPORT: begin
					if (hit_q || used_q < USED_W'(TABLE_ENTRIES)) begin
						fnd_q <= 1'b1;
						str_q <= ram_wdata.strength;
						cnt_q <= ram_wdata.count;
					end else begin
						st_q <= ST_FULL;
					end
				end
				ACT_QUERY: begin
					if (!hit_q) st_q <= ST_NOT_FOUND;
					blk_q <= hit_q && (row_q.strength > STRENGTH_HALF);
				end
				default: if (!hit_q) st_q <= ST_NOT_FOUND;
			endcase
		end
		if (state_q == S_TREAD && idx_q == '0) begin
			st_q <= ST_OK;
			fnd_q <= 1'b0;
			str_q <= '0;
			cnt_q <= '0;
			blk_q <= 1'b0;
		end
	end

	assign m_tvalid = oval_q;
	assign m_tdata = {1'b0, total_q, used_q, cnt_q, blk_q, str_q, fnd_q, st_q};

endmodule

// ===== hdl/fqt_checker.sv =====
// ----------------------------------------------------------------------------
// fqt_checker
// Port-level checks for the failure quarantine table.
// ----------------------------------------------------------------------------
module fqt_checker
	import fqt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [79:0] m_tdata
);

	// No new request is taken while a result waits.
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("request taken with result pending");

	// An accepted request leaves the block busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready) else $error("ready after request");

	// A result holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Occupancy never exceeds the table size.
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[46:40] <= 7'(TABLE_ENTRIES)) else $error("occupancy too high");

endmodule

bind failure_quarantine_table_core fqt_checker u_fqt_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== bench/tb_failure_quarantine_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_failure_quarantine_table_core
// Self-checking bench for the failure quarantine table core.
// ----------------------------------------------------------------------------
// A directed table walks the corner cases: reports up to the quarantine cap,
// queries, decay ticks, clears of present and absent keys, and a full table.
// Random traffic then works on a small pool of identifiers so that entries
// are found, decayed and cleared often. Every result is compared field by field
// with a pinned value from the directed table or with a predictor that keeps its own copy of the table.
// ----------------------------------------------------------------------------
module tb_failure_quarantine_table_core;
	import fqt_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0] action;
		logic [63:0] pattern_id;
		logic [7:0] error_code;
		logic [15:0] elapsed_ms;
	} request_t;

	typedef struct packed {
		logic [1:0] status;
		logic found;
		logic [19:0] strength;
		logic blocked;
		logic [15:0] count;
		logic [6:0] in_use;
		logic [31:0] total;
	} outcome_t;

	typedef struct {
		request_t req;
		logic chk;
		outcome_t res;
	} dir_row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [95:0] s_tdata;
	logic [79:0] m_tdata;
	logic cfg_we, cfg_index;
	logic [19:0] cfg_wdata;

	failure_quarantine_table_core DUT (.*);

	// Predictor state.
	logic [63:0] p_key [TABLE_ENTRIES];
	logic [15:0] p_count [TABLE_ENTRIES];
	logic [19:0] p_strength [TABLE_ENTRIES];
	int p_used;
	logic [31:0] p_total;
	int unsigned p_threshold, p_decay;

	outcome_t outcome_q [$];
	outcome_t pinned_q [$];
	logic pinned_valid_q [$];
	int errors = 0;
	int idle_cycles = 0;
	bit random_idle = 1;
	bit hold_off = 0;
	bit stim_done = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] fnv_key(logic [63:0] id);
		logic [63:0] h;
		h = FNV_BASIS;
		for (int b = 0; b < 8; b++) begin
			h = h ^ {56'd0, id[8*b +: 8]};
			h = h * FNV_PRIME;
		end
		return h;
	endfunction

	function automatic int find_row(logic [63:0] k);
		for (int i = 0; i < p_used; i++)
			if (p_key[i] == k) return i;
		return p_used;
	endfunction

	function automatic outcome_t predict_outcome(request_t r);
		outcome_t o;
		int i;
		longint unsigned s, d;
		o = '0;
		case (r.action)
			ACT_REPORT: begin
				i = find_row(fnv_key(r.pattern_id));
				if (i >= p_used && p_used < TABLE_ENTRIES) begin
					i = p_used;
					p_used++;
					p_key[i] = fnv_key(r.pattern_id);
					p_count[i] = 0;
					p_strength[i] = 0;
				end
				if (i < p_used) begin
					if (p_count[i] != COUNT_MAX) p_count[i]++;
					if (p_count[i] >= p_threshold) begin
						s = 500000 + 100000 * longint'(p_count[i] - p_threshold);
						p_strength[i] = (s > 1000000) ? STRENGTH_FULL : s[19:0];
					end
					o.found = 1;
					o.strength = p_strength[i];
					o.count = p_count[i];
				end else o.status = ST_FULL;
				p_total++;
			end
			ACT_TICK: begin
				d = longint'(r.elapsed_ms) * p_decay;
				for (int j = 0; j < p_used; j++)
					p_strength[j] = (p_strength[j] > d) ? p_strength[j] - d[19:0] : '0;
			end
			ACT_QUERY: begin
				i = find_row(fnv_key(r.pattern_id));
				if (i < p_used) begin
					o.found = 1;
					o.strength = p_strength[i];
					o.count = p_count[i];
					o.blocked = p_strength[i] > STRENGTH_HALF;
				end else o.status = ST_NOT_FOUND;
			end
			default: begin
				i = find_row(r.pattern_id);
				if (i < p_used) begin
					o.found = 1;
					o.strength = p_strength[i];
					o.count = p_count[i];
					for (int j = i; j + 1 < p_used; j++) begin
						p_key[j] = p_key[j+1];
						p_count[j] = p_count[j+1];
						p_strength[j] = p_strength[j+1];
					end
					p_used--;
				end else o.status = ST_NOT_FOUND;
			end
		endcase
		o.in_use = p_used[6:0];
		o.total = p_total;
		return o;
	endfunction

	task automatic send_request(request_t r, logic chk, outcome_t fixed);
		s_tdata <= {6'd0, r.elapsed_ms, r.error_code, r.pattern_id, r.action};
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		outcome_q.push_back(predict_outcome(r));
		pinned_q.push_back(fixed);
		pinned_valid_q.push_back(chk);
		@(negedge clk);
		if (random_idle && $urandom_range(99) < 30) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic idx, logic [19:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == REG_THRESHOLD) p_threshold = val[7:0];
		else p_decay = val;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (outcome_q.size() != 0) @(negedge clk);
		repeat (160) @(negedge clk);
	endtask

	// Mostly a small pool of identifiers, so that keys repeat.
	function automatic logic [63:0] pick_id();
		if ($urandom_range(9) < 8) return {$urandom_range(15), 32'h0} ^ 64'h5A;
		return {$urandom, $urandom};
	endfunction

	function automatic request_t random_request();
		request_t r;
		r.action = 2'($urandom_range(3));
		r.pattern_id = pick_id();
		r.error_code = 8'($urandom);
		r.elapsed_ms = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(200));
		if (r.action == ACT_CLEAR && $urandom_range(3) != 0) r.pattern_id = fnv_key(r.pattern_id);
		return r;
	endfunction

	function automatic request_t mk(logic [1:0] a, logic [63:0] id, logic [7:0] e, logic [15:0] ms);
		request_t r;
		r.action = a; r.pattern_id = id; r.error_code = e; r.elapsed_ms = ms;
		return r;
	endfunction

	// Output side: random stalls plus one long hold-off.
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) m_tready <= 0;
			else m_tready <= !(random_idle && $urandom_range(99) < 30);
		end
	end

	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tdata[1:0];
			got.found = m_tdata[2];
			got.strength = m_tdata[22:3];
			got.blocked = m_tdata[23];
			got.count = m_tdata[39:24];
			got.in_use = m_tdata[46:40];
			got.total = m_tdata[78:47];
			if (outcome_q.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
			end else begin
				want = outcome_q.pop_front();
				if (pinned_valid_q.pop_front()) want = pinned_q.pop_front();
				else void'(pinned_q.pop_front());
				if (got.status != want.status) begin
					$error("status expected %0d actual %0d", want.status, got.status); errors++; end
				if (got.found != want.found) begin
					$error("found expected %0d actual %0d", want.found, got.found); errors++; end
				if (got.strength != want.strength) begin
					$error("strength_out expected %0d actual %0d", want.strength, got.strength);
					errors++;
				end
				if (got.blocked != want.blocked) begin
					$error("blocked expected %0d actual %0d", want.blocked, got.blocked); errors++; end
				if (got.count != want.count) begin
					$error("count_out expected %0d actual %0d", want.count, got.count); errors++; end
				if (got.in_use != want.in_use) begin
					$error("entries_in_use expected %0d actual %0d", want.in_use, got.in_use);
					errors++;
				end
				if (got.total != want.total) begin
					$error("failures_total expected %0d actual %0d", want.total, got.total);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted request or result.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n || hold_off)
			idle_cycles <= 0;
		else if (!stim_done || outcome_q.size() != 0)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		dir_row_t dir [$];
		outcome_t none;
		logic [63:0] id_a;
		none = '0;
		id_a = 64'h0123_4567_89AB_CDEF;
		s_tvalid = 0; s_tdata = '0; cfg_we = 0; cfg_index = REG_THRESHOLD; cfg_wdata = '0;
		arst_n = 0;
		p_used = 0; p_total = 0; p_threshold = 3; p_decay = 10;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Fresh table: lookups miss, a tick on an empty table is harmless.
		dir.push_back('{mk(ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 16'd0), 1,
			'{ST_NOT_FOUND, 0, 0, 0, 0, 0, 0}});
		dir.push_back('{mk(ACT_CLEAR, 64'h0, 8'h00, 16'd0), 1,
			'{ST_NOT_FOUND, 0, 0, 0, 0, 0, 0}});
		dir.push_back('{mk(ACT_TICK, 64'h0, 8'h00, 16'hFFFF), 1, '{ST_OK, 0, 0, 0, 0, 0, 0}});
		dir.push_back('{mk(ACT_REPORT, id_a, 8'hFF, 16'd0), 1, '{ST_OK, 1, 0, 0, 1, 1, 1}});
		dir.push_back('{mk(ACT_REPORT, id_a, 8'h00, 16'd0), 1, '{ST_OK, 1, 0, 0, 2, 1, 2}});
		dir.push_back('{mk(ACT_REPORT, id_a, 8'h5A, 16'd0), 1,
			'{ST_OK, 1, 20'd500000, 0, 3, 1, 3}});
		for (int k = 0; k < 7; k++)
			dir.push_back('{mk(ACT_REPORT, id_a, 8'h11, 16'd0), 0, none});
		dir.push_back('{mk(ACT_QUERY, id_a, 8'h00, 16'd0), 1,
			'{ST_OK, 1, 20'd1000000, 1, 10, 1, 10}});
		dir.push_back('{mk(ACT_TICK, 64'h0, 8'h00, 16'd1000), 0, none});
		dir.push_back('{mk(ACT_QUERY, id_a, 8'h00, 16'd0), 0, none});
		dir.push_back('{mk(ACT_REPORT, 64'h0, 8'h01, 16'd0), 0, none});
		dir.push_back('{mk(ACT_CLEAR, fnv_key(id_a), 8'h00, 16'd0), 0, none});
		dir.push_back('{mk(ACT_QUERY, id_a, 8'h00, 16'd0), 0, none});
		foreach (dir[n]) send_request(dir[n].req, dir[n].chk, dir[n].res);
		drain();

		// Threshold at one, then fill the table past capacity.
		write_reg(REG_THRESHOLD, 20'd1);
		write_reg(REG_DECAY, 20'hFFFFF);
		for (int k = 0; k < TABLE_ENTRIES + 3; k++)
			send_request(mk(ACT_REPORT, 64'(k) << 3, 8'(k), 16'd0), 0, none);
		send_request(mk(ACT_TICK, 64'h0, 8'h0, 16'd1), 0, none);
		send_request(mk(ACT_CLEAR, fnv_key(64'd0), 8'h0, 16'd0), 0, none);
		drain();

		// Random phases under several register settings.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_THRESHOLD, 20'd255); write_reg(REG_DECAY, 20'd0); end
				1: begin write_reg(REG_THRESHOLD, 20'd0); write_reg(REG_DECAY, 20'd1000000); end
				2: begin write_reg(REG_THRESHOLD, 20'd3); write_reg(REG_DECAY, 20'd10); end
				default: begin
					write_reg(REG_THRESHOLD, 20'($urandom_range(1, 8)));
					write_reg(REG_DECAY, 20'($urandom_range(0, 5000)));
				end
			endcase
			random_idle = (ph != 3);
			for (int k = 0; k < 300; k++) begin
				if (ph == 4 && k == 20) begin
					fork
						begin
							hold_off = 1;
							repeat (400) @(negedge clk);
							hold_off = 0;
						end
					join_none
				end
				send_request(random_request(), 0, none);
			end
			drain();
		end

		stim_done = 1;
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
